[rtl/core/aifn_pkg.sv]
// aifn_pkg: widths, beat types and the column adder functions of the neuron core.
// Depends on nothing; every other file of the core imports it.
package aifn_pkg;

  localparam int WEIGHT_BITS   = 8;
  localparam int MEMBRANE_BITS = 16;
  localparam int COUNTER_BITS  = 5;
  localparam int SIGN_COL      = WEIGHT_BITS - 1;
  localparam int SKEW_COLS     = WEIGHT_BITS + COUNTER_BITS - 1;
  localparam int NUM_BLOCKS    = SKEW_COLS / 2;
  localparam int EXT_FROM      = 12;
  localparam int BLK_OUT_BITS  = 4;
  localparam int APX2_BLOCK    = 1;
  localparam int APX1_BLOCK    = 2;
  localparam int FIRE_LO       = WEIGHT_BITS;
  localparam int FIRE_HI       = MEMBRANE_BITS - 2;

  localparam logic [COUNTER_BITS-1:0] TALLY_FULL = {COUNTER_BITS{1'b1}};

  typedef logic [COUNTER_BITS-1:0]        count_t;
  typedef count_t [WEIGHT_BITS-1:0]       counts_t;
  typedef logic [WEIGHT_BITS-1:0]         weight_t;
  typedef logic [MEMBRANE_BITS-1:0]       membrane_t;
  typedef logic [2*COUNTER_BITS-1:0]      col_in_t;
  typedef logic [BLK_OUT_BITS-1:0]        col_out_t;

  typedef struct packed {
    logic      spike;
    weight_t   weight;
    membrane_t membrane_in;
    logic      first;
    logic      last;
  } in_beat_t;

  // Control from the top level to the column counters
  typedef struct packed {
    logic en;
    logic first;
    logic spike;
    logic last;
  } cnt_ctl_t;

  // Returns {carry, sum}
  function automatic logic [1:0] fa(input logic a, input logic b, input logic c);
    logic x;
    x = a ^ b;
    return {(a & b) | (c & x), x ^ c};
  endfunction

  function automatic col_out_t col_add_exact(input col_in_t n);
    logic [1:0] t0, t1, t2, t3, t4, t5;
    t0 = fa(n[0], n[2], n[4]);
    t1 = fa(n[1], n[3], n[5]);
    t2 = fa(n[6], n[8], t0[0]);
    t3 = fa(n[7], n[9], t1[0]);
    t4 = fa(t0[1], t2[1], t3[0]);
    t5 = fa(t1[1], t4[1], t3[1]);
    return {t5[1], t5[0], t4[0], t2[0]};
  endfunction

  function automatic col_out_t col_add_apx1(input col_in_t n);
    logic [1:0] t0, t1, t2, t3;
    logic       k1, k4, k5;
    t0 = fa(n[0], n[2], n[4]);
    k1 = n[6] & n[8];
    t1 = fa(n[1], n[3], n[5]);
    k4 = ~(n[7] ^ n[9]);
    k5 = n[7] | n[9];
    t2 = fa(t0[1], k1, k4);          // sum is k6, carry is o1
    t3 = fa(t1[1], k5, t2[0]);       // sum is o3, carry is o2
    return {t3[0], t3[1], t2[1], t0[0]};
  endfunction

  function automatic col_out_t col_add_apx2(input col_in_t n);
    logic [1:0] t0, t1, t2;
    logic       k1, k4, k5;
    t0 = fa(n[0], n[2], n[4]);
    k1 = n[6] & n[8];
    t1 = fa(n[1], n[3], n[5]);
    k4 = ~(n[7] ^ n[9]);
    k5 = n[7] | n[9];
    t2 = fa(t0[1], k1, k4);
    return {t1[1] & k5, t2[1], t2[0], t0[0]};
  endfunction

  // Approximate final adder: low three bits copied from b, bit 2 of a acts as carry in
  function automatic membrane_t final_add_apx(input membrane_t a, input membrane_t b);
    logic                     x3, cy;
    logic [MEMBRANE_BITS-5:0] hi;
    x3 = a[3] ^ b[3];
    cy = (a[3] & b[3]) | (x3 & a[2]);
    hi = a[MEMBRANE_BITS-1:4] + b[MEMBRANE_BITS-1:4] + {{(MEMBRANE_BITS-5){1'b0}}, cy};
    return {hi, x3 ^ a[2], b[2:0]};
  endfunction

endpackage

[rtl/core/aifn_if.sv]
// aifn_in_if and aifn_out_if: valid/ready channels of the neuron core.
// Depends on aifn_pkg for the field widths.
interface aifn_in_if import aifn_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic                            spike;
  logic signed [WEIGHT_BITS-1:0]   weight;
  logic signed [MEMBRANE_BITS-1:0] membrane_in;
  logic                            first;
  logic                            last;

  modport source(output valid, spike, weight, membrane_in, first, last, input ready);
  modport sink(input valid, spike, weight, membrane_in, first, last, output ready);
endinterface

interface aifn_out_if import aifn_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic                            fire;
  logic signed [MEMBRANE_BITS-1:0] membrane_out;

  modport source(output valid, fire, membrane_out, input ready);
  modport sink(input valid, fire, membrane_out, output ready);
endinterface

[rtl/core/approx_integrate_fire_neuron_core.sv]
// approx_integrate_fire_neuron_core: top level of the column counter neuron.
// Depends on aifn_pkg, aifn_if, aifn_col_counter and aifn_compress.
//
//   channel   dir  beat carries                                     taken when
//   synapse   in   spike, weight, membrane_in, first, last          valid & ready
//   result    out  fire, membrane_out (one per last synapse)        valid & ready
//
// One synapse per cycle, unless a stalled result or the tail pass holds it. A
// synapse beat is held in the input register, is counted and, where it flushes,
// compressed into the membrane, and its result sits in the output register. A
// last synapse that also brings the tally to 31 needs a second pass of the
// shared compressor, which flushes the empty counters. Reset (rst, synchronous)
// clears counters, tally, membrane and all valid flags. A stalled result holds
// the output register, while the input register takes non-last synapses.
module approx_integrate_fire_neuron_core import aifn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  aifn_in_if.sink     synapse,
  aifn_out_if.source  result
);

  in_beat_t  ir;
  logic      ir_valid;
  logic      ir_advance;
  logic      tail_pend;
  logic      tail_go;
  logic      out_free;
  logic      emit;
  logic      full;
  logic      fire_now;
  membrane_t potential;
  membrane_t potential_next;
  membrane_t base;
  membrane_t cmp_pin;
  membrane_t cmp_res;
  counts_t   counts_next;
  counts_t   cmp_counts;
  cnt_ctl_t  cnt_ctl;
  logic      res_valid;
  logic      res_fire;
  membrane_t res_membrane;

  // Output register is free when empty or being taken this cycle
  assign out_free   = !res_valid || result.ready;
  // A last synapse needs room for its result; hold everything during the tail pass
  assign ir_advance = ir_valid && !tail_pend && (!ir.last || out_free);
  assign tail_go    = tail_pend && out_free;
  assign synapse.ready = !ir_valid || ir_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (synapse.ready) begin
      ir_valid <= synapse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (synapse.ready && synapse.valid) begin
      ir.spike       <= synapse.spike;
      ir.weight      <= weight_t'(synapse.weight);
      ir.membrane_in <= membrane_t'(synapse.membrane_in);
      ir.first       <= synapse.first;
      ir.last        <= synapse.last;
    end
  end

  assign cnt_ctl = '{en: ir_advance, first: ir.first, spike: ir.spike, last: ir.last};

  aifn_col_counter u_counter (
    .clk         (clk),
    .rst         (rst),
    .ctl         (cnt_ctl),
    .weight      (ir.weight),
    .counts_next (counts_next),
    .full        (full)
  );

  // First synapse loads the previous membrane value
  assign base = ir.first ? ir.membrane_in : potential;

  // One compressor, shared: normal flush of the counts, or the empty tail flush
  assign cmp_counts = tail_pend ? '0 : counts_next;
  assign cmp_pin    = tail_pend ? potential : base;

  aifn_compress u_compress (
    .counts (cmp_counts),
    .pin    (cmp_pin),
    .result (cmp_res)
  );

  // Fire on a non-negative membrane with any of the upper magnitude bits set
  assign fire_now = !cmp_res[MEMBRANE_BITS-1] && (|cmp_res[FIRE_HI:FIRE_LO]);
  assign emit     = (ir_advance && ir.last && !full) || tail_go;

  always_comb begin
    potential_next = potential;
    if (tail_go) begin
      potential_next = fire_now ? '0 : cmp_res;
    end else if (ir_advance) begin
      if (full) begin
        potential_next = cmp_res;
      end else if (ir.last) begin
        potential_next = fire_now ? '0 : cmp_res;
      end else begin
        potential_next = base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      potential <= '0;
      tail_pend <= 1'b0;
    end else begin
      potential <= potential_next;
      if (ir_advance && ir.last && full) begin
        tail_pend <= 1'b1;
      end else if (tail_go) begin
        tail_pend <= 1'b0;
      end
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_fire     <= fire_now;
      res_membrane <= fire_now ? '0 : cmp_res;
    end
  end

  assign result.valid        = res_valid;
  assign result.fire         = res_fire;
  assign result.membrane_out = res_membrane;

  // A new result only follows a last synapse or the tail pass
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past((ir_advance && ir.last) || tail_go))
    else $error("result beat without a last synapse");

  // Firing always leaves a zero membrane, in the beat and in the state
  a_fire_zero: assert property (@(posedge clk) disable iff (rst)
    (emit && fire_now) |=> (potential == '0) && res_fire && (res_membrane == '0))
    else $error("membrane not cleared after firing");

  // No synapse is accepted into a full input register during the tail pass
  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    (tail_pend && ir_valid) |-> !synapse.ready)
    else $error("synapse accepted during tail flush");

endmodule

[rtl/core/aifn_col_counter.sv]
// aifn_col_counter: the eight column counters and the spike tally.
// Depends on aifn_pkg.
module aifn_col_counter import aifn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cnt_ctl_t ctl,
  input  weight_t  weight,
  output counts_t  counts_next,
  output logic     full
);

  counts_t counts;
  count_t  tally;
  count_t  tally_next;

  always_comb begin
    counts_next = ctl.first ? '0 : counts;
    tally_next  = ctl.first ? '0 : tally;
    if (ctl.spike) begin
      tally_next = tally_next + count_t'(1);
      for (int i = 0; i < WEIGHT_BITS; i++) begin
        counts_next[i] = counts_next[i] + count_t'(weight[i]);
      end
    end
    full = (tally_next == TALLY_FULL);
  end

  // Drop the counts after every flush, else advance them
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
      tally  <= '0;
    end else if (ctl.en) begin
      if (full || ctl.last) begin
        counts <= '0;
        tally  <= '0;
      end else begin
        counts <= counts_next;
        tally  <= tally_next;
      end
    end
  end

endmodule

[rtl/core/aifn_compress.sv]
// aifn_compress: skews the column counts, reduces them and adds the membrane.
// Depends on aifn_pkg for the column adders and the final adder.
module aifn_compress import aifn_pkg::*; (
  input  counts_t   counts,
  input  membrane_t pin,
  output membrane_t result
);

  logic [COUNTER_BITS-1:0][SKEW_COLS-1:0] rows;
  count_t                                 neg;
  col_in_t                                n;
  col_out_t [NUM_BLOCKS-1:0]              blk;
  membrane_t                              p0, p1, cs, cc;

  always_comb begin
    rows = '0;
    neg  = count_t'(~counts[SIGN_COL] + count_t'(1));
    for (int i = 0; i < SIGN_COL; i++) begin
      for (int j = 0; j < COUNTER_BITS; j++) begin
        rows[j][i+j] = counts[i][j];
      end
    end
    for (int j = 0; j < COUNTER_BITS; j++) begin
      rows[j][SIGN_COL+j] = neg[j];
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      for (int j = 0; j < COUNTER_BITS; j++) begin
        n[2*j]   = rows[j][2*b];
        n[2*j+1] = rows[j][2*b+1];
      end
      if (b == APX2_BLOCK) begin
        blk[b] = col_add_apx2(n);
      end else if (b == APX1_BLOCK) begin
        blk[b] = col_add_apx1(n);
      end else begin
        blk[b] = col_add_exact(n);
      end
    end
    p0 = '0;
    p1 = '0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (b % 2 == 1) begin
        p1[((b-1)/2)*BLK_OUT_BITS+2 +: BLK_OUT_BITS] = blk[b];
      end else begin
        p0[(b/2)*BLK_OUT_BITS +: BLK_OUT_BITS] = blk[b];
      end
    end
    // Sign extension of the negated sign column
    if (counts[SIGN_COL] != '0) begin
      p0[MEMBRANE_BITS-1:EXT_FROM] = '1;
    end
    cs = p0 ^ p1 ^ pin;
    cc = {((p0 & p1) | (pin & (p0 ^ p1))), 1'b0} >> 0 == '0 ? '0 :
         membrane_t'({((p0 & p1) | (pin & (p0 ^ p1))), 1'b0});
    result = final_add_apx(cs, cc);
  end

endmodule

[tb/tb_approx_integrate_fire_neuron_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for approx_integrate_fire_neuron_core: random and directed synapse
// streams, a cycle-free predictor of the column counter neuron and a result scoreboard.
// Depends on aifn_pkg, aifn_if and the core itself.
module tb_approx_integrate_fire_neuron_core;
  import aifn_pkg::*;

  localparam int        TARGET_BEATS   = 1450;
  localparam int        WATCHDOG_LIMIT = 2000;  // idle cycles
  localparam int        TAIL_CYCLES    = 24;
  localparam int        SIGN_IDX       = WEIGHT_BITS - 1;
  localparam membrane_t SIGN_EXT_MASK  = 16'hF000;

  typedef struct {
    logic      fire;
    membrane_t membrane;
  } outcome_t;

  bit   clk;
  logic rst;

  aifn_in_if  syn_if ();
  aifn_out_if res_if ();

  approx_integrate_fire_neuron_core dut (
    .clk     (clk),
    .rst     (rst),
    .synapse (syn_if),
    .result  (res_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stimulus and scoreboard stores
  in_beat_t synapse_q[$];
  outcome_t outcome_q[$];

  // Predictor state: one column counter per weight bit, spike run and membrane
  count_t    col_cnt [WEIGHT_BITS];
  count_t    spike_run;
  membrane_t membrane_acc;

  // Run bookkeeping
  int planned_beats;
  int accepted_beats;
  int neurons_done;
  int fired_count;
  int double_flushes;
  int results_seen;
  int mismatch_count;
  int stall_cycles;

  // Sender and receiver pacing
  int burst_left;
  int gap_left;
  bit beat_pending;
  bit drain_hold;
  int ready_mode;
  int ready_phase;

  in_beat_t seen_beat;
  outcome_t want;
  bit       progress;

  task automatic report_mismatch(input string what, input int wanted, input int got);
    $display("MISMATCH at result %0d: %s expected %0d got %0d", results_seen, what, wanted, got);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------
  task automatic clear_columns();
    for (int i = 0; i < WEIGHT_BITS; i++) col_cnt[i] = '0;
    spike_run = '0;
  endtask

  // Bit of the skewed partial product at row (counter bit) and column (weight significance).
  // The sign column enters negated within counter width.
  function automatic logic skew_bit(input int row, input int col);
    int     idx;
    count_t neg;
    idx = col - row;
    neg = count_t'(0) - col_cnt[SIGN_IDX];
    if (idx < 0 || idx > SIGN_IDX) return 1'b0;
    if (idx == SIGN_IDX) return neg[row];
    return col_cnt[idx][row];
  endfunction

  function automatic logic [1:0] add3(input logic a, input logic b, input logic c);
    return 2'(a) + 2'(b) + 2'(c);
  endfunction

  // Exact 5x2 column adder: plain weighted population count of the two columns
  function automatic logic [3:0] block_exact(input logic [9:0] n);
    int total;
    total = 0;
    for (int k = 0; k < COUNTER_BITS; k++) total += int'(n[2*k]) + 2 * int'(n[2*k+1]);
    return 4'(total);
  endfunction

  // Approximate block used at position two
  function automatic logic [3:0] block_apx_a(input logic [9:0] n);
    logic [1:0] lo, hi, mid, top;
    logic       k1, k4, k5;
    lo  = add3(n[0], n[2], n[4]);
    hi  = add3(n[1], n[3], n[5]);
    k1  = n[6] & n[8];
    k4  = ~(n[7] ^ n[9]);
    k5  = n[7] | n[9];
    mid = add3(lo[1], k1, k4);
    top = add3(hi[1], k5, mid[0]);
    return {top[0], top[1], mid[1], lo[0]};
  endfunction

  // Approximate block used at position one
  function automatic logic [3:0] block_apx_b(input logic [9:0] n);
    logic [1:0] lo, hi, mid;
    logic       k1, k4, k5;
    lo  = add3(n[0], n[2], n[4]);
    hi  = add3(n[1], n[3], n[5]);
    k1  = n[6] & n[8];
    k4  = ~(n[7] ^ n[9]);
    k5  = n[7] | n[9];
    mid = add3(lo[1], k1, k4);
    return {hi[1] & k5, mid[1], mid[0], lo[0]};
  endfunction

  // Final adder: low three bits pass from the carry word, bit 2 of the sum word is the
  // carry into bit 3, the rest ripples.
  function automatic membrane_t approx_sum(input membrane_t a, input membrane_t b);
    logic        cy;
    logic [11:0] hi;
    cy = (a[3] & b[3]) | ((a[3] ^ b[3]) & a[2]);
    hi = a[15:4] + b[15:4] + 12'(cy);
    return {hi, a[3] ^ b[3] ^ a[2], b[2:0]};
  endfunction

  function automatic membrane_t fold_columns(input membrane_t pin);
    membrane_t  p0, p1, cs, cc;
    logic [9:0] n;
    logic [3:0] o;
    int         b, j;
    p0 = '0;
    p1 = '0;
    for (b = 0; b < NUM_BLOCKS; b++) begin
      for (j = 0; j < COUNTER_BITS; j++) begin
        n[2*j]   = skew_bit(j, 2*b);
        n[2*j+1] = skew_bit(j, 2*b + 1);
      end
      if (b == 1) o = block_apx_b(n);
      else if (b == 2) o = block_apx_a(n);
      else o = block_exact(n);
      if (b % 2) p1 |= membrane_t'(o) << (((b - 1) / 2) * 4 + 2);
      else p0 |= membrane_t'(o) << ((b / 2) * 4);
    end
    if (col_cnt[SIGN_IDX] != '0) p0 |= SIGN_EXT_MASK;
    cs = p0 ^ p1 ^ pin;
    cc = ((p0 & p1) | (pin & (p0 ^ p1))) << 1;
    return approx_sum(cs, cc);
  endfunction

  // Advance the neuron by one synapse beat; queue the outcome on a last beat
  task automatic integrate_synapse(input in_beat_t beat);
    membrane_t settled;
    logic      fires;
    bit        full_flush;
    full_flush = 1'b0;
    if (beat.first) begin
      clear_columns();
      membrane_acc = beat.membrane_in;
    end
    if (beat.spike) begin
      spike_run++;
      for (int i = 0; i < WEIGHT_BITS; i++)
        if (beat.weight[i]) col_cnt[i]++;
    end
    if (spike_run == TALLY_FULL) begin
      membrane_acc = fold_columns(membrane_acc);
      clear_columns();
      full_flush = 1'b1;
    end
    if (beat.last) begin
      // a flush of the emptied counters still goes through the approximate adder
      settled = fold_columns(membrane_acc);
      clear_columns();
      fires = !settled[MEMBRANE_BITS-1] && (|settled[MEMBRANE_BITS-2:WEIGHT_BITS]);
      membrane_acc = fires ? '0 : settled;
      outcome_q.push_back('{fire: fires, membrane: membrane_acc});
      neurons_done++;
      if (fires) fired_count++;
      if (full_flush) double_flushes++;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------------------
  task automatic push_beat(input logic spike, input weight_t weight, input membrane_t mem,
                           input logic first, input logic last);
    in_beat_t b;
    b.spike       = spike;
    b.weight      = weight;
    b.membrane_in = mem;
    b.first       = first;
    b.last        = last;
    synapse_q.push_back(b);
    planned_beats++;
  endtask

  function automatic weight_t pick_weight();
    case (int'($urandom_range(0, 7)))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'hFF;
      3:       return 8'h00;
      default: return weight_t'($urandom);
    endcase
  endfunction

  function automatic membrane_t pick_membrane();
    case (int'($urandom_range(0, 7)))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return membrane_t'($urandom_range(0, 16'h01FF));
      default: return membrane_t'($urandom);
    endcase
  endfunction

  task automatic build_directed();
    // last with no first straight after reset: integrate from a zero membrane
    push_beat(1'b0, 8'h00, 16'h0000, 1'b0, 1'b1);
    // first and last on one beat, both weight and membrane extremes
    push_beat(1'b1, 8'h7F, 16'h7FFF, 1'b1, 1'b1);
    push_beat(1'b1, 8'h80, 16'h8000, 1'b1, 1'b1);
    // spike clear must drop the weight; then all-ones and zero weights
    push_beat(1'b0, 8'hFF, 16'h0100, 1'b1, 1'b0);
    push_beat(1'b1, 8'hFF, 16'h0000, 1'b0, 1'b0);
    push_beat(1'b1, 8'h00, 16'h0000, 1'b0, 1'b0);
    push_beat(1'b1, 8'h7F, 16'h0000, 1'b0, 1'b1);
    // carry on without first: accumulate into the membrane left by the last neuron
    push_beat(1'b1, 8'h80, 16'hFFFF, 1'b0, 1'b0);
    push_beat(1'b0, 8'h55, 16'h0000, 1'b0, 1'b1);
    // negative membrane with high bits set: must not fire
    push_beat(1'b1, 8'h01, 16'hFFFF, 1'b1, 1'b0);
    push_beat(1'b1, 8'hFF, 16'h0000, 1'b0, 1'b1);
    // just below and at the firing threshold
    push_beat(1'b1, 8'h01, 16'h00FF, 1'b1, 1'b1);
    push_beat(1'b0, 8'hAA, 16'h0100, 1'b1, 1'b1);
    push_beat(1'b1, 8'h80, 16'h7F00, 1'b1, 1'b1);
  endtask

  task automatic add_short_neuron();
    int n, pct;
    n   = $urandom_range(0, 10);
    pct = $urandom_range(0, 100);
    if (n == 0 && $urandom_range(0, 1)) begin
      push_beat($urandom_range(1, 100) <= pct, pick_weight(), pick_membrane(), 1'b1, 1'b1);
    end else begin
      push_beat($urandom_range(1, 100) <= pct, pick_weight(), pick_membrane(), 1'b1, 1'b0);
      repeat (n) push_beat($urandom_range(1, 100) <= pct, pick_weight(), pick_membrane(),
                           1'b0, 1'b0);
      push_beat($urandom_range(1, 100) <= pct, pick_weight(), pick_membrane(), 1'b0, 1'b1);
    end
  endtask

  // Long neuron whose spike count lands on a multiple of 31 at the last beat, or just past
  task automatic add_full_tally_neuron();
    int target, spikes;
    bit sp;
    target = $urandom_range(0, 1) ? 31 : 62;
    if ($urandom_range(0, 3) == 0) target += $urandom_range(1, 6);
    spikes = 1;
    push_beat(1'b1, pick_weight(), pick_membrane(), 1'b1, 1'b0);
    while (spikes < target) begin
      sp = ($urandom_range(0, 9) != 0);
      if (sp) spikes++;
      push_beat(sp, pick_weight(), pick_membrane(), 1'b0, sp && spikes == target);
    end
  endtask

  task automatic add_continuation();
    int n;
    n = $urandom_range(0, 8);
    repeat (n) push_beat(1'($urandom_range(0, 1)), pick_weight(), pick_membrane(), 1'b0, 1'b0);
    push_beat(1'($urandom_range(0, 1)), pick_weight(), pick_membrane(), 1'b0, 1'b1);
  endtask

  // Broken framing: stray firsts and lasts anywhere
  task automatic add_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) push_beat(1'($urandom_range(0, 1)), pick_weight(), pick_membrane(),
                         $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic build_random();
    int shape;
    while (planned_beats < TARGET_BEATS) begin
      shape = $urandom_range(0, 99);
      if (shape < 60) add_short_neuron();
      else if (shape < 75) add_full_tally_neuron();
      else if (shape < 88) add_continuation();
      else add_noise();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: present beats at the falling edge, in bursts with gaps between them. Hold a
  // presented beat until it is taken.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      syn_if.valid <= 1'b0;
    end else if (!beat_pending) begin
      if (drain_hold && outcome_q.size() == 0) drain_hold = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        syn_if.valid <= 1'b0;
      end else if (drain_hold || synapse_q.size() == 0) begin
        syn_if.valid <= 1'b0;
      end else begin
        syn_if.spike       <= synapse_q[0].spike;
        syn_if.weight      <= synapse_q[0].weight;
        syn_if.membrane_in <= synapse_q[0].membrane_in;
        syn_if.first       <= synapse_q[0].first;
        syn_if.last        <= synapse_q[0].last;
        syn_if.valid       <= 1'b1;
        beat_pending = 1'b1;
      end
    end
  end

  // Receiver: pick a new stall mode whenever the phase counter runs out; one mode never stalls
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (ready_phase == 0) begin
        ready_mode  = $urandom_range(0, 3);
        ready_phase = 48;
      end else begin
        ready_phase--;
      end
      case (ready_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= 1'($urandom_range(0, 1));
        2:       res_if.ready <= ($urandom_range(0, 3) == 0);
        default: res_if.ready <= ((ready_phase % 16) >= 12);
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check results against the oldest
  // outcome, then feed an accepted synapse beat to the predictor.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (res_if.valid && res_if.ready) begin
        progress = 1'b1;
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no neuron outstanding, membrane_out", 0,
                          int'(res_if.membrane_out));
        end else begin
          want = outcome_q.pop_front();
          if (res_if.fire !== want.fire)
            report_mismatch("fire", int'(want.fire), int'(res_if.fire));
          if (res_if.membrane_out !== want.membrane)
            report_mismatch("membrane_out", int'($signed(want.membrane)),
                            int'(res_if.membrane_out));
        end
        results_seen++;
      end
      if (syn_if.valid && syn_if.ready) begin
        progress              = 1'b1;
        seen_beat.spike       = syn_if.spike;
        seen_beat.weight      = syn_if.weight;
        seen_beat.membrane_in = syn_if.membrane_in;
        seen_beat.first       = syn_if.first;
        seen_beat.last        = syn_if.last;
        integrate_synapse(seen_beat);
        void'(synapse_q.pop_front());
        beat_pending = 1'b0;
        accepted_beats++;
        // hold the sender twice until every outcome so far has drained
        if (accepted_beats == 400 || accepted_beats == 950) drain_hold = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: drop out if nothing moves on either channel for too long
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: %0d idle cycles, %0d outcomes outstanding", stall_cycles,
             outcome_q.size());
    $display("tb_approx_integrate_fire_neuron_core failed");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    syn_if.valid       = 1'b0;
    syn_if.spike       = 1'b0;
    syn_if.weight      = '0;
    syn_if.membrane_in = '0;
    syn_if.first       = 1'b0;
    syn_if.last        = 1'b0;
    res_if.ready       = 1'b0;
    membrane_acc       = '0;
    clear_columns();
    burst_left         = 20;
    gap_left           = 0;
    build_directed();
    build_random();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // wait for every beat to be taken and every outcome to arrive
    while (synapse_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    // allow for stray late results
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d synapse beats over %0d neurons: %0d fired, %0d double flushes",
             accepted_beats, neurons_done, fired_count, double_flushes);
    $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_approx_integrate_fire_neuron_core passed");
    end else begin
      $display("tb_approx_integrate_fire_neuron_core failed");
    end
    $finish;
  end

endmodule
